>>> rtl/core/cbta_pkg.sv
// Package for the calendar block time advance core.
// Field types, register indexes and calendar constants; no dependencies.
package cbta_pkg;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [15:0] blk_min_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_idx_t REG_BLOCK_MINUTES = 3'd0;
  localparam cfg_idx_t REG_END_YEAR      = 3'd1;
  localparam cfg_idx_t REG_END_MONTH     = 3'd2;
  localparam cfg_idx_t REG_END_DAY       = 3'd3;
  localparam cfg_idx_t REG_END_HOUR      = 3'd4;
  localparam cfg_idx_t REG_END_MINUTE    = 3'd5;

  localparam blk_min_t RST_BLOCK_MINUTES = 16'd60;
  localparam year_t    RST_END_YEAR      = 12'd2020;
  localparam month_t   RST_END_MONTH     = 4'd12;
  localparam day_t     RST_END_DAY       = 5'd31;
  localparam hour_t    RST_END_HOUR      = 5'd23;
  localparam minute_t  RST_END_MINUTE    = 6'd59;

  localparam blk_min_t MIN_PER_DAY  = 16'd1440;
  localparam blk_min_t MIN_PER_HOUR = 16'd60;
  localparam hour_t    LAST_HOUR    = 5'd23;
  localparam month_t   LAST_MONTH   = 4'd12;

  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_APR = 4'd4;
  localparam month_t MON_JUN = 4'd6;
  localparam month_t MON_SEP = 4'd9;
  localparam month_t MON_NOV = 4'd11;

  function automatic day_t last_day(month_t month, logic [1:0] year_lo);
    day_t d;
    d = 5'd31;
    if (month == MON_FEB) begin
      d = (year_lo == 2'd0) ? 5'd29 : 5'd28;
    end else if (month == MON_APR || month == MON_JUN || month == MON_SEP ||
                 month == MON_NOV) begin
      d = 5'd30;
    end
    return d;
  endfunction

endpackage

>>> rtl/core/cbta_in_if.sv
// Input channel of the calendar block time advance core.
// Valid/ready handshake carrying one timestamp; depends on cbta_pkg.
interface cbta_in_if;
  import cbta_pkg::*;
  logic    valid;
  logic    ready;
  year_t   in_year;
  month_t  in_month;
  day_t    in_day;
  hour_t   in_hour;
  minute_t in_minute;

  modport source (output valid, in_year, in_month, in_day, in_hour, in_minute,
                  input ready);
  modport sink   (input valid, in_year, in_month, in_day, in_hour, in_minute,
                  output ready);
endinterface

>>> rtl/core/cbta_out_if.sv
// Result channel of the calendar block time advance core.
// Valid/ready handshake carrying the advanced timestamp; depends on cbta_pkg.
interface cbta_out_if;
  import cbta_pkg::*;
  logic    valid;
  logic    ready;
  year_t   out_year;
  month_t  out_month;
  day_t    out_day;
  hour_t   out_hour;
  minute_t out_minute;
  logic    not_after_end;

  modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
                  not_after_end, input ready);
  modport sink   (input valid, out_year, out_month, out_day, out_hour, out_minute,
                  not_after_end, output ready);
endinterface

>>> rtl/core/calendar_block_time_advance.sv
// Calendar block time advance: one timestamp in, advanced timestamp out.
// Depends on cbta_pkg, cbta_in_if and cbta_out_if.
//
// A single subtract-and-compare unit first splits block_minutes into days,
// hours and minutes (one step per day and per hour), then the same calendar
// step logic adds the minute and hour parts with carries and one whole day
// per cycle. The input is not ready while a transaction is in work; a
// finished result sits in the output register, so the next transaction is
// accepted while it waits. The end flag compares the raw input fields
// against the end registers.
module calendar_block_time_advance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  cbta_pkg::cfg_idx_t  cfg_idx,
  input  cbta_pkg::cfg_data_t cfg_wdata,
  cbta_in_if.sink             in_chan,
  cbta_out_if.source          out_chan
);
  import cbta_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DAYS   = 3'd1;
  localparam logic [2:0] S_HRS    = 3'd2;
  localparam logic [2:0] S_MIN    = 3'd3;
  localparam logic [2:0] S_HOUR   = 3'd4;
  localparam logic [2:0] S_DAYADD = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  blk_min_t blk_min_r;
  year_t    end_year_r;
  month_t   end_month_r;
  day_t     end_day_r;
  hour_t    end_hour_r;
  minute_t  end_minute_r;

  logic [2:0] state_r, state_nxt;
  blk_min_t   rem_r, rem_nxt;
  logic [5:0] days_r, days_nxt;
  hour_t      hrs_r, hrs_nxt;
  year_t      year_r, year_nxt;
  month_t     month_r, month_nxt;
  day_t       day_r, day_nxt;
  hour_t      hour_r, hour_nxt;
  minute_t    minute_r, minute_nxt;
  logic       nae_r, nae_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;

  year_t      out_year_r;
  month_t     out_month_r;
  day_t       out_day_r;
  hour_t      out_hour_r;
  minute_t    out_minute_r;
  logic       out_nae_r;

  logic       accept;
  logic       sub_ge;
  blk_min_t   sub_k, sub_diff;
  year_t      nd_year;
  month_t     nd_month;
  day_t       nd_day;
  logic [6:0] min_sum;
  logic [5:0] hour_sum;

  assign accept       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_min_r    <= RST_BLOCK_MINUTES;
      end_year_r   <= RST_END_YEAR;
      end_month_r  <= RST_END_MONTH;
      end_day_r    <= RST_END_DAY;
      end_hour_r   <= RST_END_HOUR;
      end_minute_r <= RST_END_MINUTE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BLOCK_MINUTES: blk_min_r    <= cfg_wdata;
        REG_END_YEAR:      end_year_r   <= cfg_wdata[11:0];
        REG_END_MONTH:     end_month_r  <= cfg_wdata[3:0];
        REG_END_DAY:       end_day_r    <= cfg_wdata[4:0];
        REG_END_HOUR:      end_hour_r   <= cfg_wdata[4:0];
        REG_END_MINUTE:    end_minute_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // shared subtract-and-compare unit
  assign sub_k    = (state_r == S_DAYS) ? MIN_PER_DAY : MIN_PER_HOUR;
  assign sub_ge   = (rem_r >= sub_k);
  assign sub_diff = rem_r - sub_k;

  // one calendar day step on the working timestamp
  always_comb begin
    nd_year  = year_r;
    nd_month = month_r;
    nd_day   = day_r + 5'd1;
    if (day_r >= last_day(month_r, year_r[1:0])) begin
      nd_day = 5'd1;
      if (month_r < LAST_MONTH) begin
        nd_month = month_r + 4'd1;
      end else begin
        nd_month = 4'd1;
        nd_year  = year_r + 12'd1;
      end
    end
  end

  assign min_sum  = {1'b0, minute_r} + {1'b0, rem_r[5:0]};
  assign hour_sum = {1'b0, hour_r} + {1'b0, hrs_r};
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    hrs_nxt    = hrs_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    nae_nxt    = nae_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          year_nxt   = in_chan.in_year;
          month_nxt  = in_chan.in_month;
          day_nxt    = in_chan.in_day;
          hour_nxt   = in_chan.in_hour;
          minute_nxt = in_chan.in_minute;
          nae_nxt    = {end_year_r, end_month_r, end_day_r, end_hour_r, end_minute_r} >=
                       {in_chan.in_year, in_chan.in_month, in_chan.in_day,
                        in_chan.in_hour, in_chan.in_minute};
          rem_nxt    = blk_min_r;
          days_nxt   = '0;
          hrs_nxt    = '0;
          state_nxt  = S_DAYS;
        end
      end
      S_DAYS: begin
        if (sub_ge) begin
          rem_nxt  = sub_diff;
          days_nxt = days_r + 6'd1;
        end else begin
          state_nxt = S_HRS;
        end
      end
      S_HRS: begin
        if (sub_ge) begin
          rem_nxt = sub_diff;
          hrs_nxt = hrs_r + 5'd1;
        end else begin
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (min_sum < 7'd60) begin
          minute_nxt = min_sum[5:0];
        end else begin
          minute_nxt = 6'(min_sum - 7'd60);
          if (hour_r < LAST_HOUR) begin
            hour_nxt = hour_r + 5'd1;
          end else begin
            hour_nxt  = '0;
            year_nxt  = nd_year;
            month_nxt = nd_month;
            day_nxt   = nd_day;
          end
        end
        state_nxt = S_HOUR;
      end
      S_HOUR: begin
        if (hour_sum < 6'd24) begin
          hour_nxt = hour_sum[4:0];
        end else begin
          hour_nxt  = 5'(hour_sum - 6'd24);
          year_nxt  = nd_year;
          month_nxt = nd_month;
          day_nxt   = nd_day;
        end
        state_nxt = S_DAYADD;
      end
      S_DAYADD: begin
        if (days_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          year_nxt  = nd_year;
          month_nxt = nd_month;
          day_nxt   = nd_day;
          days_nxt  = days_r - 6'd1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    days_r   <= days_nxt;
    hrs_r    <= hrs_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    nae_r    <= nae_nxt;
    if (out_load) begin
      out_year_r   <= year_r;
      out_month_r  <= month_r;
      out_day_r    <= day_r;
      out_hour_r   <= hour_r;
      out_minute_r <= minute_r;
      out_nae_r    <= nae_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_year      = out_year_r;
  assign out_chan.out_month     = out_month_r;
  assign out_chan.out_day       = out_day_r;
  assign out_chan.out_hour      = out_hour_r;
  assign out_chan.out_minute    = out_minute_r;
  assign out_chan.not_after_end = out_nae_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DAYS)
    else $error("accepted transaction did not start the day split");

  a_hrs_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HRS |-> rem_r < MIN_PER_DAY)
    else $error("hour split entered with a full day left");

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MIN |-> rem_r < MIN_PER_HOUR && hrs_r <= LAST_HOUR)
    else $error("minute step entered with bad remainder");

  a_days_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DAYADD |-> days_r <= 6'd45)
    else $error("day count out of range");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result load did not raise valid");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Testbench for calendar_block_time_advance: timestamps in, advanced timestamps out.
// Predicts results from its own calendar arithmetic and register copy; typed rows give theirs.
// Depends on cbta_pkg, cbta_in_if, cbta_out_if and the core.
module testbench;
  import cbta_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 217;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
  } stamp_t;

  typedef struct packed {
    stamp_t stamp;
    logic   not_after_end;
  } result_t;

  typedef struct {
    stamp_t  stamp;
    bit      typed;
    result_t want;
  } vector_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_wdata;

  cbta_in_if  in_bus ();
  cbta_out_if out_bus ();

  calendar_block_time_advance u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  blk_min_t    blk_len;
  stamp_t      end_stamp;
  result_t     pending_results[$];
  vector_t     directed_rows[$];
  result_t     oldest;
  int unsigned mismatches;
  int unsigned sent;
  int unsigned checked;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  bit          gappy;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic day_t month_length(month_t m, year_t y);
    case (m) inside
      MON_FEB: return (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic void step_month(inout stamp_t s);
    if (s.month < LAST_MONTH) begin
      s.month = s.month + 1'b1;
    end else begin
      s.month = 4'd1;
      s.year  = s.year + 1'b1;
    end
  endfunction

  function automatic void step_day(inout stamp_t s);
    if (s.day < month_length(s.month, s.year)) begin
      s.day = s.day + 1'b1;
    end else begin
      s.day = 5'd1;
      step_month(s);
    end
  endfunction

  function automatic void step_hour(inout stamp_t s);
    if (s.hour < LAST_HOUR) begin
      s.hour = s.hour + 1'b1;
    end else begin
      s.hour = 5'd0;
      step_day(s);
    end
  endfunction

  function automatic result_t advance_stamp(stamp_t s);
    result_t     r;
    int unsigned add_min;
    int unsigned add_hr;
    int unsigned add_days;
    int unsigned sum;
    r.not_after_end = (s <= end_stamp);
    add_min  = blk_len % MIN_PER_HOUR;
    add_hr   = (blk_len / MIN_PER_HOUR) % 24;
    add_days = blk_len / MIN_PER_DAY;
    sum = s.minute + add_min;
    if (sum < 60) begin
      s.minute = 6'(sum);
    end else begin
      s.minute = 6'(sum - 60);
      step_hour(s);
    end
    sum = s.hour + add_hr;
    if (sum < 24) begin
      s.hour = 5'(sum);
    end else begin
      s.hour = 5'(sum - 24);
      step_day(s);
    end
    repeat (add_days) step_day(s);
    r.stamp = s;
    return r;
  endfunction

  function automatic stamp_t ts(int y, int m, int d, int h, int mi);
    stamp_t s;
    s.year   = 12'(y);
    s.month  = 4'(m);
    s.day    = 5'(d);
    s.hour   = 5'(h);
    s.minute = 6'(mi);
    return s;
  endfunction

  function automatic vector_t row(stamp_t s, bit typed, stamp_t want, bit flag);
    vector_t v;
    v.stamp = s;
    v.typed = typed;
    v.want.stamp = want;
    v.want.not_after_end = flag;
    return v;
  endfunction

  function automatic void add_row(vector_t v);
    directed_rows.insert(directed_rows.size(), v);
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t s;
    day_t   ld;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      s = stamp_t'($urandom);
    end else if (pick < 35) begin
      s = end_stamp;
      case ($urandom_range(0, 5))
        0: s.year[0]   = ~s.year[0];
        1: s.month[0]  = ~s.month[0];
        2: s.day[0]    = ~s.day[0];
        3: s.hour[0]   = ~s.hour[0];
        4: s.minute[0] = ~s.minute[0];
        default: ;
      endcase
    end else begin
      s.year  = 12'($urandom_range(0, 4095));
      s.month = 4'($urandom_range(1, 12));
      ld = month_length(s.month, s.year);
      case ($urandom_range(0, 3))
        0: s.day = 5'd1;
        1: s.day = ld - 1'b1;
        2: s.day = ld;
        default: s.day = 5'($urandom_range(1, ld));
      endcase
      s.hour   = $urandom_range(0, 3) == 0 ? 5'd23 : 5'($urandom_range(0, 23));
      s.minute = $urandom_range(0, 3) == 0 ? 6'd59 : 6'($urandom_range(0, 59));
    end
    return s;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gappy ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_stamp(stamp_t s, bit typed, result_t want);
    in_bus.valid     <= 1'b1;
    in_bus.in_year   <= s.year;
    in_bus.in_month  <= s.month;
    in_bus.in_day    <= s.day;
    in_bus.in_hour   <= s.hour;
    in_bus.in_minute <= s.minute;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.insert(pending_results.size(), typed ? want : advance_stamp(s));
    sent++;
    pace();
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(cfg_data_t vals[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (cfg_idx_t'(i))
        REG_BLOCK_MINUTES: blk_len          = vals[i];
        REG_END_YEAR:      end_stamp.year   = vals[i][11:0];
        REG_END_MONTH:     end_stamp.month  = vals[i][3:0];
        REG_END_DAY:       end_stamp.day    = vals[i][4:0];
        REG_END_HOUR:      end_stamp.hour   = vals[i][4:0];
        REG_END_MINUTE:    end_stamp.minute = vals[i][5:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall pattern of its own, plus one long hold on request.
  initial begin
    int          mode;
    int          len;
    int unsigned tick;
    tick = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(32, 256);
      repeat (len) begin
        @(posedge clk);
        tick++;
        if (hold_req) begin
          out_bus.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_bus.ready <= 1'b1;
            1: out_bus.ready <= ($urandom_range(0, 3) != 0);
            2: out_bus.ready <= 1'($urandom_range(0, 1));
            default: out_bus.ready <= ((tick % 5) < 2);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        report("result arrived with nothing pending");
      end else begin
        oldest = pending_results.pop_front();
        check_field("year",   out_bus.out_year,      oldest.stamp.year);
        check_field("month",  out_bus.out_month,     oldest.stamp.month);
        check_field("day",    out_bus.out_day,       oldest.stamp.day);
        check_field("hour",   out_bus.out_hour,      oldest.stamp.hour);
        check_field("minute", out_bus.out_minute,    oldest.stamp.minute);
        check_field("not_after_end", out_bus.not_after_end, oldest.not_after_end);
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_data_t vals[6];
    result_t   none;
    none = '0;
    mismatches = 0;
    sent = 0;
    checked = 0;
    quiet_cycles = 0;
    burst_left = 1;
    gappy = 1'b1;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_BLOCK_MINUTES;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.in_year <= '0;
    in_bus.in_month <= '0;
    in_bus.in_day <= '0;
    in_bus.in_hour <= '0;
    in_bus.in_minute <= '0;
    blk_len = RST_BLOCK_MINUTES;
    end_stamp = ts(RST_END_YEAR, RST_END_MONTH, RST_END_DAY, RST_END_HOUR, RST_END_MINUTE);

    add_row(row(ts(2020, 12, 31, 23, 59), 1, ts(2021, 1, 1, 0, 59), 1));
    add_row(row(ts(2021, 1, 1, 0, 0), 1, ts(2021, 1, 1, 1, 0), 0));
    add_row(row(ts(4095, 12, 31, 23, 30), 1, ts(0, 1, 1, 0, 30), 0));
    add_row(row(ts(2024, 2, 28, 23, 0), 1, ts(2024, 2, 29, 0, 0), 0));
    add_row(row(ts(2023, 2, 28, 23, 10), 1, ts(2023, 3, 1, 0, 10), 0));
    add_row(row(ts(0, 0, 0, 0, 0), 1, ts(0, 0, 0, 1, 0), 1));
    add_row(row(ts(4095, 15, 31, 31, 63), 0, '0, 0));
    add_row(row(ts(2019, 4, 30, 23, 45), 0, '0, 0));
    add_row(row(ts(2019, 4, 31, 23, 0), 0, '0, 0));
    add_row(row(ts(2019, 13, 5, 23, 0), 0, '0, 0));
    add_row(row(ts(2019, 15, 31, 23, 0), 0, '0, 0));
    add_row(row(ts(2000, 6, 15, 24, 0), 0, '0, 0));
    add_row(row(ts(2001, 2, 31, 23, 60), 0, '0, 0));
    add_row(row(ts(2020, 15, 0, 0, 0), 0, '0, 0));
    add_row(row(ts(2020, 12, 31, 23, 59), 0, '0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_stamp(directed_rows[i].stamp, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      vals[REG_BLOCK_MINUTES] = 16'd0;
      vals[REG_END_YEAR]   = 16'($urandom_range(0, 4095));
      vals[REG_END_MONTH]  = 16'($urandom_range(1, 12));
      vals[REG_END_DAY]    = 16'($urandom_range(1, 28));
      vals[REG_END_HOUR]   = 16'($urandom_range(0, 23));
      vals[REG_END_MINUTE] = 16'($urandom_range(0, 59));
      case (p)
        0: begin
          foreach (vals[i]) vals[i] = '0;
        end
        1: begin
          vals[REG_BLOCK_MINUTES] = 16'hFFFF;
          vals[REG_END_YEAR]   = 16'd4095;
          vals[REG_END_MONTH]  = 16'd15;
          vals[REG_END_DAY]    = 16'd31;
          vals[REG_END_HOUR]   = 16'd31;
          vals[REG_END_MINUTE] = 16'd63;
        end
        2: begin
          vals[REG_BLOCK_MINUTES] = 16'd44640;
          vals[REG_END_YEAR]   = 16'(RST_END_YEAR);
          vals[REG_END_MONTH]  = 16'(RST_END_MONTH);
          vals[REG_END_DAY]    = 16'(RST_END_DAY);
          vals[REG_END_HOUR]   = 16'(RST_END_HOUR);
          vals[REG_END_MINUTE] = 16'(RST_END_MINUTE);
        end
        3: vals[REG_BLOCK_MINUTES] = 16'd1439;
        4: vals[REG_BLOCK_MINUTES] = 16'd1440;
        5: vals[REG_BLOCK_MINUTES] = 16'd59;
        6: begin
          foreach (vals[i]) vals[i] = 16'($urandom_range(0, 65535));
        end
        default: vals[REG_BLOCK_MINUTES] = 16'($urandom_range(1, 3000));
      endcase
      load_settings(vals);
      gappy = (p % 3 != 0);
      if (p == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_stamp(random_stamp(), 0, none);
      end
      drain();
    end

    $display("Sent %0d timestamps over %0d register settings plus reset defaults;",
             sent, PHASES);
    $display("checked %0d results, %0d mismatches.", checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cbta_pkg.sv
rtl/core/cbta_in_if.sv
rtl/core/cbta_out_if.sv
rtl/core/calendar_block_time_advance.sv
test/testbench.sv
